// File: rtl/core/itoa_pkg.sv
// shared types, constants and tables for the integer to ascii converter
`timescale 1ns / 1ps
package itoa_pkg;

  // converted value width and derived widths
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int SH_W        = $clog2(2 * VALUE_WIDTH);
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int DIGIT_W     = 6;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 6;

  // character and radix constants
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam int RADIX_CNT = 35;
  localparam int RTAB_W    = $clog2(RADIX_CNT);

  // reciprocal table: floor(2^(VALUE_WIDTH-1+j) / r), j = floor(log2 r)
  localparam int DIV_W = VALUE_WIDTH + 8;
  localparam logic [DIV_W-1:0] DIV_ONE = DIV_W'(1);
  localparam logic [VALUE_WIDTH-1:0] RECIP_TABLE [RADIX_CNT] = '{
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 0)) / DIV_W'(2)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 0)) / DIV_W'(3)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 1)) / DIV_W'(4)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 1)) / DIV_W'(5)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 1)) / DIV_W'(6)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 1)) / DIV_W'(7)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(8)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(9)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(10)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(11)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(12)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(13)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(14)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 2)) / DIV_W'(15)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(16)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(17)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(18)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(19)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(20)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(21)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(22)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(23)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(24)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(25)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(26)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(27)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(28)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(29)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(30)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 3)) / DIV_W'(31)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 4)) / DIV_W'(32)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 4)) / DIV_W'(33)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 4)) / DIV_W'(34)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 4)) / DIV_W'(35)),
    VALUE_WIDTH'((DIV_ONE << (VALUE_WIDTH + 4)) / DIV_W'(36))
  };

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_SIGN,
    ST_DIGIT
  } itoa_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
    logic step;
    logic sel_sign;
  } itoa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic neg;
    logic idx_zero;
  } itoa_status_t;

  // product shift for a clamped radix: VALUE_WIDTH - 1 + floor(log2 r)
  function automatic logic [SH_W-1:0] radix_shift(input logic [RADIX_W-1:0] r);
    int j;
    j = 1;
    if (r[5]) j = 5;
    else if (r[4]) j = 4;
    else if (r[3]) j = 3;
    else if (r[2]) j = 2;
    return SH_W'(VALUE_WIDTH - 1 + j);
  endfunction

endpackage

// File: rtl/core/itoa_intf.sv
// request and character channel interfaces
`timescale 1ns / 1ps
interface itoa_in_if;
  import itoa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   opcode;
  logic [RADIX_W-1:0]     radix;
  logic [CHAR_W-1:0]      letter_start;

  modport source (output valid, value, opcode, radix, letter_start, input ready);
  modport sink   (input valid, value, opcode, radix, letter_start, output ready);
endinterface

interface itoa_out_if;
  import itoa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic [LEN_W-1:0]  length;

  modport source (output valid, character, last, length, input ready);
  modport sink   (input valid, character, last, length, output ready);
endinterface

// File: rtl/core/itoa_ctrl.sv
// controller state machine: division loop and character sequencing
`timescale 1ns / 1ps
module itoa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  itoa_pkg::itoa_status_t st_i,
  output itoa_pkg::itoa_cmd_t    cmd_o
);
  import itoa_pkg::*;

  itoa_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        if (st_i.div_done) begin
          state_d = st_i.neg ? ST_SIGN : ST_DIGIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
        if (out_ready_i) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.step = 1'b1;
          if (st_i.idx_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/itoa_dp.sv
// datapath: magnitude, reciprocal divide by radix, digit store, character build
`timescale 1ns / 1ps
module itoa_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0]     value_i,
  input  logic                                 opcode_i,
  input  logic [itoa_pkg::RADIX_W-1:0]         radix_i,
  input  logic [itoa_pkg::CHAR_W-1:0]          letter_start_i,
  output logic [itoa_pkg::CHAR_W-1:0]          character_o,
  output logic                                 last_o,
  output logic [itoa_pkg::LEN_W-1:0]           length_o,
  input  itoa_pkg::itoa_cmd_t                  cmd_i,
  output itoa_pkg::itoa_status_t               st_o
);
  import itoa_pkg::*;

  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0]      quot_q;
  logic [VW-1:0]      recip_q;
  logic [SH_W-1:0]    shift_q;
  logic [RADIX_W-1:0] radix_q;
  logic [CHAR_W-1:0]  letter_q;
  logic               neg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   idx_q;
  logic [PROD_W-1:0]  prod_q;
  logic [DIGIT_W-1:0] store_q [VALUE_WIDTH];

  logic               neg_in;
  logic [VW-1:0]      mag_in;
  logic [RADIX_W-1:0] radix_clamp;
  logic [VW-1:0]      quot_est;
  logic [VW-1:0]      quot_fix;
  logic [6:0]         qr_lo;
  logic [6:0]         rem_est;
  logic               fix_up;
  logic [DIGIT_W-1:0] digit_new;
  logic [DIGIT_W-1:0] digit_rd;

  // sign handling and radix saturation on the request
  assign neg_in = opcode_i & value_i[VW-1];
  assign mag_in = neg_in ? (VW'(0) - value_i) : value_i;

  always_comb begin
    if (radix_i < RADIX_MIN) begin
      radix_clamp = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_clamp = RADIX_MAX;
    end else begin
      radix_clamp = radix_i;
    end
  end

  // quotient estimate is exact or one low; remainder fits seven bits
  assign quot_est  = VW'(prod_q >> shift_q);
  assign qr_lo     = 7'({6'd0, quot_est[6:0]} * {7'd0, radix_q});
  assign rem_est   = quot_q[6:0] - qr_lo;
  assign fix_up    = rem_est >= {1'b0, radix_q};
  assign digit_new = fix_up ? DIGIT_W'(rem_est - {1'b0, radix_q}) : rem_est[DIGIT_W-1:0];
  assign quot_fix  = fix_up ? (quot_est + VW'(1)) : quot_est;

  // control-side datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        quot_q <= mag_in;
        cnt_q  <= '0;
        neg_q  <= neg_in;
      end else if (cmd_i.fix) begin
        quot_q <= quot_fix;
        cnt_q  <= cnt_q + CNT_W'(1);
        idx_q  <= cnt_q[IDX_W-1:0];
      end else if (cmd_i.step) begin
        idx_q  <= idx_q - IDX_W'(1);
      end
    end
  end

  // request operands and reciprocal product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q  <= radix_clamp;
      letter_q <= letter_start_i;
      recip_q  <= RECIP_TABLE[RTAB_W'(radix_clamp - RADIX_MIN)];
      shift_q  <= radix_shift(radix_clamp);
    end
    if (cmd_i.mul) begin
      prod_q <= {{VW{1'b0}}, quot_q} * {{VW{1'b0}}, recip_q};
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      store_q[cnt_q[IDX_W-1:0]] <= digit_new;
    end
  end

  // status
  assign st_o.div_done = (quot_fix == '0) || (cnt_q == CNT_W'(VALUE_WIDTH - 1));
  assign st_o.neg      = neg_q;
  assign st_o.idx_zero = (idx_q == '0);

  // output character
  assign digit_rd = store_q[idx_q];

  always_comb begin
    if (cmd_i.sel_sign) begin
      character_o = CHAR_MINUS;
    end else if (digit_rd < DIGIT_TEN) begin
      character_o = CHAR_ZERO + {2'b00, digit_rd};
    end else begin
      character_o = letter_q + {2'b00, digit_rd} - {2'b00, DIGIT_TEN};
    end
  end

  assign last_o   = !cmd_i.sel_sign && (idx_q == '0);
  assign length_o = LEN_W'(cnt_q) + LEN_W'(neg_q);

endmodule

// File: rtl/core/integer_to_ascii_any_base_core.sv
// top level: integer to ascii text in radix 2 to 36, sent out one character at a time
// sequence: accept, then per digit a reciprocal multiply, then a correction, for D digits
// first character is offered once the last digit has been corrected
// requests: a new one is taken only in idle, after the last character of the previous one;
// D is up to 32 for radix 2; the shared divide step sets the loop
// reset: rst_ni asynchronous, active low; returns to idle, digit store is not cleared
`timescale 1ns / 1ps
module integer_to_ascii_any_base_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_in_if.sink     in_i,
  itoa_out_if.source  out_o
);
  import itoa_pkg::*;

  itoa_cmd_t    cmd;
  itoa_status_t st;

  // sequencing
  itoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // conversion datapath
  itoa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (in_i.value),
    .opcode_i       (in_i.opcode),
    .radix_i        (in_i.radix),
    .letter_start_i (in_i.letter_start),
    .character_o    (out_o.character),
    .last_o         (out_o.last),
    .length_o       (out_o.length),
    .cmd_i          (cmd),
    .st_o           (st)
  );

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the integer to ascii converter core
`timescale 1ns / 1ps
module tb_top;
  import itoa_pkg::*;

  // request opcodes
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 600;

  // one character of converted text
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic [LEN_W-1:0]  length;
  } text_char_t;

  // one directed request; empty text means the prediction is computed
  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   op;
    logic [RADIX_W-1:0]     radix;
    logic [CHAR_W-1:0]      letter;
    string                  text;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  itoa_in_if  in_if ();
  itoa_out_if out_if ();

  integer_to_ascii_any_base_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  text_char_t pending_chars [$];
  stim_row_t  stim_table [$];
  int         mismatch_cnt  = 0;
  int         send_gap_pct  = 0;
  int         sink_idle_pct = 0;
  bit         calm          = 0;
  bit         hold_req      = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // expected text typed in by hand
  function automatic void expect_text(string s);
    text_char_t item;
    int len;
    len = s.len();
    for (int i = 0; i < len; i++) begin
      item.character = s[i];
      item.last      = (i == len - 1);
      item.length    = LEN_W'(len);
      pending_chars.push_back(item);
    end
  endfunction

  // predicted text of one conversion
  function automatic void predict_text(logic [VALUE_WIDTH-1:0] value, logic op,
                                       logic [RADIX_W-1:0] radix, logic [CHAR_W-1:0] letter);
    logic [RADIX_W-1:0]     base;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic [DIGIT_W-1:0]     digits [VALUE_WIDTH];
    int                     n;
    int                     total;
    text_char_t             item;
    base = radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    neg = (op == OP_SIGNED) && value[VALUE_WIDTH-1];
    mag = neg ? VALUE_WIDTH'(0) - value : value;
    n = 0;
    if (mag == 0) begin
      digits[0] = '0;
      n = 1;
    end
    while (mag != 0 && n < VALUE_WIDTH) begin
      digits[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end
    total = n + (neg ? 1 : 0);
    item.length = LEN_W'(total);
    if (neg) begin
      item.character = CHAR_MINUS;
      item.last      = 1'b0;
      pending_chars.push_back(item);
    end
    // most significant digit first
    for (int i = n - 1; i >= 0; i--) begin
      if (digits[i] < DIGIT_TEN) item.character = CHAR_ZERO + digits[i];
      else item.character = letter + (digits[i] - DIGIT_TEN);
      item.last = (i == 0);
      pending_chars.push_back(item);
    end
  endfunction

  function automatic void add_row(logic [VALUE_WIDTH-1:0] value, logic op,
                                  logic [RADIX_W-1:0] radix, logic [CHAR_W-1:0] letter,
                                  string text);
    stim_row_t row;
    row.value  = value;
    row.op     = op;
    row.radix  = radix;
    row.letter = letter;
    row.text   = text;
    stim_table.push_back(row);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    case ($urandom_range(0, 4))
      0:       return VALUE_WIDTH'($urandom_range(0, 40));
      1:       return VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1);
      2:       return VALUE_WIDTH'(0) - VALUE_WIDTH'($urandom_range(1, 100));
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    if ($urandom_range(0, 9) == 0) return RADIX_W'($urandom_range(0, 63));
    return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
  endfunction

  // offer one request, wait for it to be taken, then maybe idle
  task automatic send_item(logic [VALUE_WIDTH-1:0] value, logic op, logic [RADIX_W-1:0] radix,
                           logic [CHAR_W-1:0] letter, string text);
    in_if.valid        <= 1'b1;
    in_if.value        <= value;
    in_if.opcode       <= op;
    in_if.radix        <= radix;
    in_if.letter_start <= letter;
    do @(posedge clk_i); while (!in_if.ready);
    if (text.len() != 0) expect_text(text);
    else predict_text(value, op, radix, letter);
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    send_item(random_value(), 1'($urandom_range(0, 1)), random_radix(),
              CHAR_W'($urandom_range(0, 255)), "");
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // character receiver with random stalls and one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // compare each character taken against the oldest expectation
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected character %02h last %0b length %0d",
                   out_if.character, out_if.last, out_if.length);
      end else begin
        want = pending_chars.pop_front();
        if (want != {out_if.character, out_if.last, out_if.length}) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected char %02h last %0b length %0d, got %02h %0b %0d",
                     want.character, want.last, want.length,
                     out_if.character, out_if.last, out_if.length);
        end
      end
    end
  end

  // reset, directed table, random phases, end of run
  initial begin
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.value        <= '0;
    in_if.opcode       <= OP_UNSIGNED;
    in_if.radix        <= RADIX_MIN;
    in_if.letter_start <= 8'h61;

    // zero, extremes, both opcodes, radix saturation, letter wrap
    add_row(32'h0000_0000, OP_UNSIGNED, 6'd10, 8'h61, "0");
    add_row(32'h0000_0000, OP_SIGNED,   6'd2,  8'h61, "0");
    add_row(32'hFFFF_FFFF, OP_UNSIGNED, 6'd16, 8'h61, "ffffffff");
    add_row(32'hFFFF_FFFF, OP_UNSIGNED, 6'd16, 8'h41, "FFFFFFFF");
    add_row(32'hFFFF_FFFF, OP_SIGNED,   6'd10, 8'h61, "-1");
    add_row(32'h8000_0000, OP_SIGNED,   6'd10, 8'h61, "-2147483648");
    add_row(32'h8000_0000, OP_SIGNED,   6'd2,  8'h61, "-10000000000000000000000000000000");
    add_row(32'hFFFF_FFFF, OP_UNSIGNED, 6'd2,  8'h61, "11111111111111111111111111111111");
    add_row(32'h8000_0000, OP_UNSIGNED, 6'd36, 8'h61, "");
    add_row(32'h7FFF_FFFF, OP_SIGNED,   6'd10, 8'h61, "2147483647");
    add_row(32'hFFFF_FFFF, OP_UNSIGNED, 6'd10, 8'h61, "4294967295");
    add_row(32'd5,         OP_UNSIGNED, 6'd0,  8'h61, "101");
    add_row(32'd5,         OP_UNSIGNED, 6'd1,  8'h61, "101");
    add_row(32'd35,        OP_UNSIGNED, 6'd63, 8'h41, "Z");
    add_row(32'd35,        OP_UNSIGNED, 6'd37, 8'h61, "z");
    add_row(32'd35,        OP_UNSIGNED, 6'd36, 8'hFF, "");
    add_row(32'd10,        OP_UNSIGNED, 6'd11, 8'h00, "");
    add_row(32'hFFFF_FFFF, OP_UNSIGNED, 6'd36, 8'h61, "");
    add_row(32'd123456789, OP_SIGNED,   6'd8,  8'h61, "");
    add_row(32'd9,         OP_UNSIGNED, 6'd10, 8'h61, "9");
    add_row(32'd10,        OP_UNSIGNED, 6'd16, 8'h61, "a");
    add_row(32'h8000_0000, OP_SIGNED,   6'd16, 8'h41, "-80000000");
    add_row(32'd1,         OP_SIGNED,   6'd2,  8'h61, "1");
    add_row(32'hDEAD_BEEF, OP_SIGNED,   6'd16, 8'h61, "");
    add_row(32'hFFFF_FFFF, OP_SIGNED,   6'd36, 8'h61, "-1");

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table with light idling
    send_gap_pct  = 15;
    sink_idle_pct = 10;
    foreach (stim_table[i])
      send_item(stim_table[i].value, stim_table[i].op, stim_table[i].radix,
                stim_table[i].letter, stim_table[i].text);

    // random, moderate idling
    send_gap_pct  = 20;
    sink_idle_pct = 20;
    repeat (40) send_random();

    // receiver holds off while requests keep coming
    hold_req = 1;
    repeat (8)
      send_item(random_value(), 1'($urandom_range(0, 1)), RADIX_MIN,
                CHAR_W'($urandom_range(0, 255)), "");

    // sender pauses until all text is out
    in_if.valid <= 1'b0;
    wait_drained();

    // random, heavy idling
    send_gap_pct  = 50;
    sink_idle_pct = 40;
    repeat (50) send_random();

    // random, no idling at all
    calm = 1;
    repeat (37) send_random();
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (120) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
